[sv/ordered_list_insert_remove_search_top_defines.svh]
// assertion macros for the ordered list block
// used by ordered_list_insert_remove_search_top, which provides clk_i and rst_ni
`ifndef ORDERED_LIST_INSERT_REMOVE_SEARCH_TOP_DEFINES_SVH
`define ORDERED_LIST_INSERT_REMOVE_SEARCH_TOP_DEFINES_SVH

// property that holds at every clock edge outside reset
`define OLIST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define OLIST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/olist_pkg.sv]
// types and constants for the ordered list block
// no dependencies
package olist_pkg;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned ValW     = 32;
  localparam int unsigned PosW     = 6;
  localparam int unsigned FoundW   = 7;
  localparam int unsigned StatW    = 2;
  localparam int unsigned LenW     = 7;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;

  localparam logic [FoundW-1:0] FoundNone = '1;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_DONE  = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_PUT,
    S_DOWN,
    S_SEARCH,
    S_DONE
  } state_e;

endpackage

[sv/ordered_list_insert_remove_search_top.sv]
// Bounded ordered list of signed 32-bit values kept packed in one single-port-write,
// one-read memory of CAPACITY entries. Append writes the tail entry on accept. Insert
// and remove shift the later entries one memory access per cycle, insert from the tail
// down to the position and remove from the position up to the tail; search walks from the
// head until the first match or the tail. One command is worked at a time; the next one is
// accepted as soon as the previous result sits in the output register, even before it is
// taken.
// depends on olist_pkg and ordered_list_insert_remove_search_top_defines.svh
`include "ordered_list_insert_remove_search_top_defines.svh"

module ordered_list_insert_remove_search_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // value [31:0], position [37:32], zero [39:38]
  input  logic [olist_pkg::InDataW-1:0]  s_axis_tdata,
  // cmd [1:0]
  input  logic [olist_pkg::CmdW-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // found_index [6:0], status [8:7], list_length [15:9]
  output logic [olist_pkg::OutDataW-1:0] m_axis_tdata
);
  import olist_pkg::*;

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CW > PosW) ? CW : PosW;
  localparam logic [CW-1:0] CntOne = 1;
  localparam logic [AW-1:0] IdxOne = 1;
  localparam logic [CW-1:0] CntMax = CW'(CAPACITY);

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [ValW-1:0] val_q, val_d;
  logic [FoundW-1:0] found_q, found_d;
  status_e stat_q, stat_d;
  logic out_vld_q;
  logic [OutDataW-1:0] out_data_q;

  logic [ValW-1:0] mem [CAPACITY];
  logic [ValW-1:0] rd_data_q;
  logic rd_en, we;
  logic [AW-1:0] rd_addr, wa;
  logic [ValW-1:0] wd;

  cmd_e in_cmd;
  logic [ValW-1:0] in_val;
  logic [PosW-1:0] in_pos;
  logic in_acc, out_free;
  logic is_full, is_empty, pos_ge, pos_last;
  logic up_end, dn_end, hit, walk_end;
  logic [AW-1:0] last_idx;
  logic [CmpW-1:0] pos_ext, cnt_ext;

  assign in_cmd   = cmd_e'(s_axis_tuser);
  assign in_val   = s_axis_tdata[ValW-1:0];
  assign in_pos   = s_axis_tdata[ValW+PosW-1:ValW];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  assign pos_ext  = CmpW'(in_pos);
  assign cnt_ext  = CmpW'(cnt_q);
  assign last_idx = AW'(cnt_q - CntOne);
  assign is_full  = (cnt_q == CntMax);
  assign is_empty = (cnt_q == '0);
  assign pos_ge   = (pos_ext >= cnt_ext);
  assign pos_last = (pos_ext == CmpW'(cnt_q - CntOne));
  assign up_end   = (idx_q == pos_q);
  assign dn_end   = (idx_q == last_idx);
  assign walk_end = (idx_q == last_idx);
  assign hit      = (rd_data_q == val_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_DONE;
          case (in_cmd)
            CMD_INSERT: if (!is_full && !pos_ge) state_d = S_UP;
            CMD_REMOVE: if (!pos_ge && !pos_last) state_d = S_DOWN;
            CMD_SEARCH: if (!is_empty) state_d = S_SEARCH;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_UP:     if (up_end) state_d = S_PUT;
      S_PUT:    state_d = S_DONE;
      S_DOWN:   if (dn_end) state_d = S_DONE;
      S_SEARCH: if (hit || walk_end) state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // memory accesses and datapath updates
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_q;
    we      = 1'b0;
    wa      = idx_q;
    wd      = rd_data_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    val_d   = val_q;
    found_d = found_q;
    stat_d  = stat_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          val_d   = in_val;
          pos_d   = AW'(in_pos);
          found_d = FoundNone;
          stat_d  = STAT_DONE;
          case (in_cmd)
            CMD_APPEND: begin
              if (is_full) begin
                stat_d = STAT_FULL;
              end else begin
                we    = 1'b1;
                wa    = AW'(cnt_q);
                wd    = in_val;
                cnt_d = cnt_q + CntOne;
              end
            end
            CMD_INSERT: begin
              if (is_full) begin
                stat_d = STAT_FULL;
              end else if (pos_ge) begin
                stat_d = STAT_RANGE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = last_idx;
                idx_d   = last_idx;
              end
            end
            CMD_REMOVE: begin
              if (pos_ge) begin
                stat_d = STAT_RANGE;
              end else if (pos_last) begin
                cnt_d = cnt_q - CntOne;
              end else begin
                rd_en   = 1'b1;
                rd_addr = AW'(in_pos) + IdxOne;
                idx_d   = AW'(in_pos) + IdxOne;
              end
            end
            default: begin
              if (!is_empty) begin
                rd_en   = 1'b1;
                rd_addr = '0;
                idx_d   = '0;
              end
            end
          endcase
        end
      end
      // write and read addresses are two apart, so no forwarding is needed
      S_UP: begin
        we = 1'b1;
        wa = idx_q + IdxOne;
        if (!up_end) begin
          rd_en   = 1'b1;
          rd_addr = idx_q - IdxOne;
          idx_d   = idx_q - IdxOne;
        end
      end
      S_PUT: begin
        we    = 1'b1;
        wa    = pos_q;
        wd    = val_q;
        cnt_d = cnt_q + CntOne;
      end
      S_DOWN: begin
        we = 1'b1;
        wa = idx_q - IdxOne;
        if (dn_end) begin
          cnt_d = cnt_q - CntOne;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_q + IdxOne;
          idx_d   = idx_q + IdxOne;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          found_d = FoundW'(idx_q);
        end else if (!walk_end) begin
          rd_en   = 1'b1;
          rd_addr = idx_q + IdxOne;
          idx_d   = idx_q + IdxOne;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == S_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    val_q   <= val_d;
    found_q <= found_d;
    stat_q  <= stat_d;
    if (state_q == S_DONE && out_free) begin
      out_data_q <= {LenW'(cnt_q), stat_q, found_q};
    end
  end

  `OLIST_ASSERT(a_len_bound, cnt_q <= CntMax, "entry count beyond capacity")
  `OLIST_ASSERT(a_wr_bound, !we || (CW'(wa) < CntMax), "memory write beyond capacity")
  `OLIST_ASSERT(a_no_rw_clash, !(we && rd_en) || (wa != rd_addr), "read and write hit one entry")
  `OLIST_ASSERT_NEXT(a_one_at_a_time, in_acc, !s_axis_tready, "beat taken while busy")

endmodule

[verif/olist_result_checker.sv]
// result checker for the ordered list block: predicts every command beat and compares results
// keeps its own copy of the list, depends on olist_pkg
// hands the failure count, pending results and predicted length to the testbench top
module olist_result_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // value [31:0], position [37:32], zero [39:38]
  input  logic [olist_pkg::InDataW-1:0]  s_axis_tdata,
  // cmd [1:0]
  input  logic [olist_pkg::CmdW-1:0]     s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // found_index [6:0], status [8:7], list_length [15:9]
  input  logic [olist_pkg::OutDataW-1:0] m_axis_tdata,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o,
  output logic [olist_pkg::LenW-1:0]     list_len_o
);
  import olist_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  // first member in the highest bits
  typedef struct packed {
    logic [LenW-1:0]   len;
    status_e           status;
    logic [FoundW-1:0] found;
  } list_result_t;

  logic [ValW-1:0] shadow_store [CAPACITY];
  int unsigned     shadow_count;
  list_result_t    expected_q [$];
  int unsigned     fails = 0;
  list_result_t    got_res;
  list_result_t    want_res;

  assign fail_count_o = fails;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fails < 50) begin
      $display("mismatch %s: got %0h want %0h", what, got, want);
    end
    fails++;
  endtask

  function automatic list_result_t apply_cmd(cmd_e c, logic [ValW-1:0] v,
                                             logic [PosW-1:0] p);
    list_result_t r;
    r.found  = FoundNone;
    r.status = STAT_DONE;
    case (c)
      CMD_APPEND: begin
        if (shadow_count >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          shadow_store[AW'(shadow_count)] = v;
          shadow_count++;
        end
      end
      CMD_INSERT: begin
        // full wins over position
        if (shadow_count >= CAPACITY) begin
          r.status = STAT_FULL;
        end else if (p >= shadow_count) begin
          r.status = STAT_RANGE;
        end else begin
          for (int i = int'(shadow_count); i > int'(p); i--) begin
            shadow_store[AW'(i)] = shadow_store[AW'(i-1)];
          end
          shadow_store[AW'(p)] = v;
          shadow_count++;
        end
      end
      CMD_REMOVE: begin
        if (p >= shadow_count) begin
          r.status = STAT_RANGE;
        end else begin
          for (int i = int'(p); i < int'(shadow_count) - 1; i++) begin
            shadow_store[AW'(i)] = shadow_store[AW'(i+1)];
          end
          shadow_count--;
        end
      end
      default: begin
        for (int i = 0; i < int'(shadow_count); i++) begin
          if (shadow_store[AW'(i)] == v) begin
            r.found = FoundW'(i);
            break;
          end
        end
      end
    endcase
    r.len = LenW'(shadow_count);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_count = 0;
      expected_q.delete();
      pending_o  <= 0;
      list_len_o <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = list_result_t'(m_axis_tdata);
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with nothing expected", 32'(m_axis_tdata), 32'd0);
        end else begin
          want_res = expected_q.pop_front();
          if (got_res.found !== want_res.found) begin
            report_mismatch("found_index", 32'(got_res.found), 32'(want_res.found));
          end
          if (got_res.status !== want_res.status) begin
            report_mismatch("status", 32'(got_res.status), 32'(want_res.status));
          end
          if (got_res.len !== want_res.len) begin
            report_mismatch("list_length", 32'(got_res.len), 32'(want_res.len));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(apply_cmd(cmd_e'(s_axis_tuser), s_axis_tdata[ValW-1:0],
                                       s_axis_tdata[ValW+PosW-1:ValW]));
      end
      pending_o  <= expected_q.size();
      list_len_o <= LenW'(shadow_count);
    end
  end

endmodule

[verif/tb_ordered_list_insert_remove_search_top.sv]
// testbench top for the ordered list block: clock, reset, command stimulus and verdict
// directed edge cases, then grow, mixed and shrink phases under varying back-pressure
// depends on olist_pkg, ordered_list_insert_remove_search_top and olist_result_checker
module tb_ordered_list_insert_remove_search_top;
  import olist_pkg::*;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS  = 120;
  localparam int unsigned NUM_PHASES   = 7;

  typedef enum logic [1:0] {
    MIX_GROW,
    MIX_BALANCE,
    MIX_SHRINK
  } mix_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [CmdW-1:0]     s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  int unsigned     fail_count;
  int unsigned     pending;
  logic [LenW-1:0] list_len;
  int unsigned     cycle_count  = 0;
  int unsigned     src_idle_pct = 0;
  int unsigned     dst_stall_pct = 0;
  logic [ValW-1:0] value_pool [8];

  always #2 clk_i = ~clk_i;

  ordered_list_insert_remove_search_top #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  olist_result_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .list_len_o   (list_len)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= dst_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_beat(input cmd_e c, input logic [ValW-1:0] v,
                           input logic [PosW-1:0] p);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, p, v};
    s_axis_tuser  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [ValW-1:0] pick_value(int unsigned pool_pct);
    if ($urandom_range(0, 99) < pool_pct) begin
      return value_pool[3'($urandom_range(0, 7))];
    end
    return $urandom();
  endfunction

  task automatic random_item(input mix_e mix);
    int unsigned     r;
    int unsigned     len;
    cmd_e            c;
    logic [ValW-1:0] v;
    logic [PosW-1:0] p;
    len = 32'(list_len);
    r   = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        c = (r < 55) ? CMD_APPEND : (r < 80) ? CMD_INSERT : (r < 88) ? CMD_REMOVE : CMD_SEARCH;
      end
      MIX_SHRINK: begin
        c = (r < 10) ? CMD_APPEND : (r < 20) ? CMD_INSERT : (r < 75) ? CMD_REMOVE : CMD_SEARCH;
      end
      default: begin
        c = (r < 25) ? CMD_APPEND : (r < 50) ? CMD_INSERT : (r < 75) ? CMD_REMOVE : CMD_SEARCH;
      end
    endcase
    v = pick_value((c == CMD_SEARCH) ? 85 : 65);
    r = $urandom_range(0, 99);
    if (r < 70) begin
      p = PosW'($urandom_range(0, (len == 0) ? 0 : len - 1));
    end else if (r < 80) begin
      p = '0;
    end else if (r < 88) begin
      // just past the tail, or the last position when the list is full
      p = (len > 63) ? 6'd63 : PosW'(len);
    end else begin
      p = PosW'($urandom_range(0, 63));
    end
    send_beat(c, v, p);
  endtask

  initial begin
    mix_e mix;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 8; i++) begin
      value_pool[3'(i)] = $urandom();
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty list cases
    send_beat(CMD_SEARCH, 32'h0000_0000, 6'd0);
    send_beat(CMD_REMOVE, 32'h0000_0000, 6'd0);
    send_beat(CMD_INSERT, 32'h0000_0001, 6'd0);
    // extreme values
    send_beat(CMD_APPEND, 32'h8000_0000, 6'd0);
    send_beat(CMD_APPEND, 32'h7fff_ffff, 6'd63);
    send_beat(CMD_APPEND, 32'h0000_0000, 6'd0);
    send_beat(CMD_APPEND, 32'hffff_ffff, 6'd0);
    send_beat(CMD_SEARCH, 32'h7fff_ffff, 6'd0);
    send_beat(CMD_SEARCH, 32'h1234_5678, 6'd0);
    // head and middle insert, out of range insert
    send_beat(CMD_INSERT, 32'h0000_0005, 6'd0);
    send_beat(CMD_INSERT, 32'haaaa_aaaa, 6'd2);
    send_beat(CMD_INSERT, 32'h5555_5555, 6'd63);
    send_beat(CMD_INSERT, 32'h5555_5555, 6'd6);
    // tail and head remove, out of range remove
    send_beat(CMD_REMOVE, 32'h0000_0000, 6'd5);
    send_beat(CMD_REMOVE, 32'h0000_0000, 6'd0);
    send_beat(CMD_REMOVE, 32'hffff_ffff, 6'd63);
    // duplicates, first match wins
    send_beat(CMD_SEARCH, 32'hffff_ffff, 6'd0);
    send_beat(CMD_APPEND, 32'h0000_0000, 6'd0);
    send_beat(CMD_SEARCH, 32'h0000_0000, 6'd0);
    send_beat(CMD_SEARCH, 32'h8000_0000, 6'd0);
    send_beat(CMD_SEARCH, 32'h5555_5555, 6'd0);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
        1: begin src_idle_pct = 49; dst_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  dst_stall_pct = 49; end
        default: begin src_idle_pct = 28; dst_stall_pct = 28; end
      endcase
      case (ph % 3)
        0: mix = MIX_GROW;
        1: mix = MIX_BALANCE;
        default: mix = MIX_SHRINK;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_item(mix);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
